// ----- rtl/sfs_pkg.sv -----
// sfs_pkg: shared types, constants and helpers for the sprite frame sequencer
// no dependencies

package sfs_pkg;

	// position and sequence length; a sequence holds at most 2*MAX_FRAMES-2 positions
	localparam int POS_W = 8;

	// item commands
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_LOOP_EN     = 2'd0,
		CFG_PINGPONG_EN = 2'd1,
		CFG_FRAME_COUNT = 2'd2,
		CFG_LOOP_START  = 2'd3
	} cfg_idx_t;

	// source frame shown at a position of the (possibly mirrored) sequence
	function automatic logic [POS_W-1:0] source_of(input logic [POS_W-1:0] pos,
			input logic [POS_W-1:0] n);
		logic [POS_W-1:0] mirror;
		begin
			mirror = (n << 1) - POS_W'(2) - pos;
			source_of = (pos < n) ? pos : mirror;
		end
	endfunction

endpackage

// ----- rtl/sfs_ram.sv -----
// sfs_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module sfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/sprite_frame_sequencer.sv -----
// sprite_frame_sequencer: animation frame sequencer with a duration table in RAM
// depends on sfs_pkg and sfs_ram
//
// a result passes through the input register and then the result register; throughput
// is one item per cycle on a flowing output. the duration of the next frame is
// prefetched from the table, so a tick never waits on the RAM port. reset clears
// sequencer state and configuration; the duration table is not cleared and must be
// loaded before it is played.

module sprite_frame_sequencer
	import sfs_pkg::*;
#(
	parameter int MAX_FRAMES    = 64,
	parameter int DURATION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // [5:0] slot, [21:6] duration_ms, [23:22] zero
	input  logic [1:0]  s_tuser,    // [1:0] command
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata     // [6:0] seq_position, [12:7] source_frame,
	                                // [13] expired, [14] frame_enter, [15] expire_event
);

	localparam int DW = DURATION_BITS;
	localparam int AW = $clog2(MAX_FRAMES);

	// configuration
	logic       loop_en_q;
	logic       pp_en_q;
	logic [6:0] frame_cnt_q;
	logic [6:0] loop_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_en_q    <= 1'b0;
			pp_en_q      <= 1'b0;
			frame_cnt_q  <= 7'd1;
			loop_start_q <= 7'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LOOP_EN:     loop_en_q    <= cfg_data[0];
				CFG_PINGPONG_EN: pp_en_q      <= cfg_data[0];
				CFG_FRAME_COUNT: frame_cnt_q  <= cfg_data;
				CFG_LOOP_START:  loop_start_q <= cfg_data;
			endcase
		end
	end

	// input register
	logic        s1_valid;
	cmd_t        cmd_s1;
	logic [5:0]  slot_s1;
	logic [15:0] dur_s1;
	logic        adv;
	logic        out_valid_q;

	assign adv      = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= cmd_t'(s_tuser);
			slot_s1 <= s_tdata[5:0];
			dur_s1  <= s_tdata[21:6];
		end
	end

	// sequencer state
	logic [POS_W-1:0] pos_q;
	logic [DW-1:0]    time_q;
	logic             done_q;
	logic [POS_W-1:0] last_q;
	logic             rptv_q;
	logic             exprep_q;

	logic [POS_W-1:0] pos_d;
	logic [DW-1:0]    time_d;
	logic             done_d;
	logic [POS_W-1:0] last_d;
	logic             rptv_d;
	logic             exprep_d;
	logic             enter;
	logic             exp_ev;

	// duration table
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;
	logic          byp_q;
	logic [DW-1:0] byp_data_q;
	logic [DW-1:0] cur_dur;

	sfs_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_FRAMES)
	) u_dur_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// a load to the slot being prefetched forwards the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= ram_wdata;
	end

	assign cur_dur = byp_q ? byp_data_q : ram_rdata;

	// zero loads as one, wide values saturate
	logic [DW-1:0] dur_w;
	generate
		if (DW >= 16) begin : g_dur_wide
			always_comb begin
				dur_w = DW'(dur_s1);
				if (dur_s1 == 16'd0) dur_w = DW'(1);
			end
		end else begin : g_dur_narrow
			always_comb begin
				dur_w = (|(dur_s1 >> DW)) ? {DW{1'b1}} : dur_s1[DW-1:0];
				if (dur_s1 == 16'd0) dur_w = DW'(1);
			end
		end
	endgenerate

	assign ram_we    = adv && (cmd_s1 == CMD_LOAD) && (32'(slot_s1) < MAX_FRAMES);
	assign ram_waddr = AW'(slot_s1);
	assign ram_wdata = dur_w;

	// sequence geometry from configuration
	logic [POS_W-1:0] n;
	logic [POS_W-1:0] len;
	logic [POS_W-1:0] posc;
	logic [POS_W-1:0] ls;
	logic [DW:0]      t_inc;
	logic [POS_W-1:0] src_out;

	always_comb begin
		if (frame_cnt_q == 7'd0) begin
			n = POS_W'(1);
		end else if (32'(frame_cnt_q) > MAX_FRAMES) begin
			n = POS_W'(MAX_FRAMES);
		end else begin
			n = POS_W'(frame_cnt_q);
		end
		len  = (pp_en_q && n >= POS_W'(3)) ? (n << 1) - POS_W'(2) : n;
		posc = (pos_q >= len) ? len - POS_W'(1) : pos_q;
		ls   = POS_W'(loop_start_q);
	end

	// next state for the item in the input register
	always_comb begin
		pos_d    = posc;
		time_d   = time_q;
		done_d   = done_q;
		last_d   = last_q;
		rptv_d   = rptv_q;
		exprep_d = exprep_q;
		enter    = 1'b0;
		exp_ev   = 1'b0;
		t_inc    = {1'b0, time_q} + (DW+1)'(1);

		case (cmd_s1)
			CMD_START: begin
				pos_d    = '0;
				time_d   = '0;
				done_d   = 1'b0;
				rptv_d   = 1'b0;
				exprep_d = 1'b0;
			end
			CMD_TICK: begin
				if (!done_q) begin
					if (t_inc >= {1'b0, cur_dur}) begin
						time_d = '0;
						if (posc + POS_W'(1) >= len) begin
							if (loop_en_q) begin
								pos_d = (ls < len) ? ls : '0;
							end else begin
								done_d = 1'b1;
							end
						end else begin
							pos_d = posc + POS_W'(1);
						end
					end else begin
						time_d = t_inc[DW-1:0];
					end
				end
			end
			default: begin
			end
		endcase

		if (done_d) begin
			if (!exprep_d) begin
				exp_ev   = 1'b1;
				exprep_d = 1'b1;
			end
		end else begin
			exprep_d = 1'b0;
			if (!rptv_d || last_d != pos_d) begin
				enter  = 1'b1;
				last_d = pos_d;
				rptv_d = 1'b1;
			end
		end

		src_out = source_of(pos_d, n);
	end

	// prefetch the duration of the frame the next item will see
	assign ram_raddr = adv ? AW'(src_out) : AW'(source_of(posc, n));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			time_q   <= '0;
			done_q   <= 1'b0;
			last_q   <= '0;
			rptv_q   <= 1'b0;
			exprep_q <= 1'b0;
		end else if (adv) begin
			pos_q    <= pos_d;
			time_q   <= time_d;
			done_q   <= done_d;
			last_q   <= last_d;
			rptv_q   <= rptv_d;
			exprep_q <= exprep_d;
		end
	end

	// result register
	logic [15:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {exp_ev, enter, done_d, src_out[5:0], pos_d[6:0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
